### hw/rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character constants and classification functions for the
// infix to prefix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int unsigned DefaultCapacity = 64;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;

  localparam logic [1:0] PrecAdd   = 2'd1;
  localparam logic [1:0] PrecMul   = 2'd2;
  localparam logic [1:0] PrecOther = 2'd3;

  // datapath commands issued by the controller
  typedef struct packed {
    logic accept;
    logic char_rd;
    logic emit_char;
    logic set_cur;
    logic push;
    logic pop;
    logic reload_top;
    logic emit_rd;
    logic out_load;
    logic out_empty;
    logic clear;
  } itp_cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic in_xfer;
    logic in_last;
    logic count_zero;
    logic is_operand;
    logic is_space;
    logic depth_zero;
    logic prec_lt;
    logic res_zero;
    logic out_xfer;
    logic out_end;
  } itp_status_t;

  function automatic logic is_operand(input logic [7:0] c);
    return ((c >= Ch0) && (c <= Ch9)) || ((c >= ChLoA) && (c <= ChLoZ)) ||
           ((c >= ChUpA) && (c <= ChUpZ));
  endfunction

  function automatic logic [1:0] precedence(input logic [7:0] c);
    logic [1:0] p;
    if ((c == ChPlus) || (c == ChMinus)) begin
      p = PrecAdd;
    end else if ((c == ChStar) || (c == ChSlash)) begin
      p = PrecMul;
    end else begin
      p = PrecOther;
    end
    return p;
  endfunction

endpackage

### hw/rtl/itp_ctrl.sv
// ----------------------------------------------------------------------------
// itp_ctrl
// Controller state machine: collects characters, steps the reversed
// shunting-yard conversion and sequences the reversed emission.
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itp_pkg::itp_status_t status_i,
  output itp_pkg::itp_cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    StCollect  = 10'b00_0000_0001,
    StFetch    = 10'b00_0000_0010,
    StClassify = 10'b00_0000_0100,
    StCmp      = 10'b00_0000_1000,
    StReload   = 10'b00_0001_0000,
    StFlush    = 10'b00_0010_0000,
    StFreload  = 10'b00_0100_0000,
    StEmitLd   = 10'b00_1000_0000,
    StEmitWait = 10'b01_0000_0000,
    StIdle     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StCollect;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StCollect: begin
        cmd_o.accept = 1'b1;
        if (status_i.in_xfer && status_i.in_last) begin
          state_d = StFetch;
        end
      end
      StFetch: begin
        if (status_i.count_zero) begin
          state_d = StFlush;
        end else begin
          cmd_o.char_rd = 1'b1;
          state_d       = StClassify;
        end
      end
      StClassify: begin
        if (status_i.is_operand) begin
          cmd_o.emit_char = 1'b1;
          state_d         = StFetch;
        end else if (status_i.is_space) begin
          state_d = StFetch;
        end else begin
          cmd_o.set_cur = 1'b1;
          state_d       = StCmp;
        end
      end
      StCmp: begin
        if (!status_i.depth_zero && status_i.prec_lt) begin
          cmd_o.pop = 1'b1;
          state_d   = StReload;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = StFetch;
        end
      end
      StReload: begin
        cmd_o.reload_top = 1'b1;
        state_d          = StCmp;
      end
      StFlush: begin
        if (!status_i.depth_zero) begin
          cmd_o.pop = 1'b1;
          state_d   = StFreload;
        end else if (status_i.res_zero) begin
          cmd_o.out_empty = 1'b1;
          state_d         = StEmitWait;
        end else begin
          cmd_o.emit_rd = 1'b1;
          state_d       = StEmitLd;
        end
      end
      StFreload: begin
        cmd_o.reload_top = 1'b1;
        state_d          = StFlush;
      end
      StEmitLd: begin
        cmd_o.out_load = 1'b1;
        state_d        = StEmitWait;
      end
      StEmitWait: begin
        if (status_i.out_xfer) begin
          if (status_i.out_end) begin
            state_d = StIdle;
          end else begin
            cmd_o.emit_rd = 1'b1;
            state_d       = StEmitLd;
          end
        end
      end
      StIdle: begin
        // return counts and flag to zero for the next expression
        cmd_o.clear = 1'b1;
        state_d     = StCollect;
      end
      default: begin
        state_d = StCollect;
      end
    endcase
  end

endmodule

### hw/rtl/itp_dp.sv
// ----------------------------------------------------------------------------
// itp_dp
// Datapath: character buffer, operator stack and result buffer memories,
// their counters, the cached stack top and the output register.
// ----------------------------------------------------------------------------
module itp_dp #(
  parameter int unsigned Capacity = itp_pkg::DefaultCapacity
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itp_pkg::itp_cmd_t    cmd_i,
  output itp_pkg::itp_status_t status_o,
  input  logic                 in_valid_i,
  input  logic [7:0]           ch_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_char_o,
  output logic                 end_mark_o,
  output logic                 nothing_o,
  output logic                 overflowed_o
);

  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);
  localparam logic [CntW-1:0] One    = CntW'(1);
  localparam logic [CntW-1:0] Two    = CntW'(2);

  logic [7:0] char_mem [Capacity];
  logic [7:0] stk_mem  [Capacity];
  logic [7:0] res_mem  [Capacity];

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] depth_q, depth_d;
  logic [CntW-1:0] res_cnt_q, res_cnt_d;
  logic            dropped_q, dropped_d;
  logic            out_valid_q;

  logic [7:0] char_rd_q, stk_rd_q, res_rd_q;
  logic [7:0] cur_q, top_q;
  logic [7:0] out_char_q;
  logic       out_end_q, out_nothing_q, out_ovf_q;

  logic            in_xfer, out_xfer, room;
  logic [CntW-1:0] char_rd_cnt, stk_rd_cnt, res_rd_cnt;
  logic            res_wr;
  logic [7:0]      res_wr_data;

  assign in_xfer     = in_valid_i & cmd_i.accept;
  assign out_xfer    = out_valid_q & ~out_stall_i;
  assign room        = count_q < CapCnt;
  assign char_rd_cnt = count_q - One;
  assign stk_rd_cnt  = depth_q - Two;
  assign res_rd_cnt  = res_cnt_q - One;
  assign res_wr      = cmd_i.emit_char | cmd_i.pop;
  assign res_wr_data = cmd_i.pop ? top_q : char_rd_q;

  // memories
  always_ff @(posedge clk_i) begin
    if (in_xfer && room) begin
      char_mem[count_q[AddrW-1:0]] <= ch_i;
    end
    if (cmd_i.char_rd) begin
      char_rd_q <= char_mem[char_rd_cnt[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stk_mem[depth_q[AddrW-1:0]] <= cur_q;
    end
    // next entry down becomes the top once a pop completes
    if (cmd_i.pop) begin
      stk_rd_q <= stk_mem[stk_rd_cnt[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      res_mem[res_cnt_q[AddrW-1:0]] <= res_wr_data;
    end
    if (cmd_i.emit_rd) begin
      res_rd_q <= res_mem[res_rd_cnt[AddrW-1:0]];
    end
  end

  // counters and flag
  always_comb begin
    count_d   = count_q;
    depth_d   = depth_q;
    res_cnt_d = res_cnt_q;
    dropped_d = dropped_q;
    if (in_xfer) begin
      if (room) begin
        count_d = count_q + One;
      end else begin
        dropped_d = 1'b1;
      end
    end
    if (cmd_i.char_rd) begin
      count_d = char_rd_cnt;
    end
    if (cmd_i.push) begin
      depth_d = depth_q + One;
    end
    if (cmd_i.pop) begin
      depth_d = depth_q - One;
    end
    if (res_wr) begin
      res_cnt_d = res_cnt_q + One;
    end
    if (cmd_i.emit_rd) begin
      res_cnt_d = res_rd_cnt;
    end
    if (cmd_i.clear) begin
      count_d   = '0;
      depth_d   = '0;
      res_cnt_d = '0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      depth_q     <= '0;
      res_cnt_q   <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      depth_q   <= depth_d;
      res_cnt_q <= res_cnt_d;
      dropped_q <= dropped_d;
      if (cmd_i.out_load || cmd_i.out_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_cur) begin
      cur_q <= char_rd_q;
    end
    if (cmd_i.push) begin
      top_q <= cur_q;
    end else if (cmd_i.reload_top) begin
      top_q <= stk_rd_q;
    end
    if (cmd_i.out_load) begin
      out_char_q    <= res_rd_q;
      out_end_q     <= (res_cnt_q == '0);
      out_nothing_q <= 1'b0;
      out_ovf_q     <= dropped_q;
    end else if (cmd_i.out_empty) begin
      out_char_q    <= '0;
      out_end_q     <= 1'b1;
      out_nothing_q <= 1'b1;
      out_ovf_q     <= dropped_q;
    end
  end

  assign status_o.in_xfer    = in_xfer;
  assign status_o.in_last    = last_i;
  assign status_o.count_zero = (count_q == '0);
  assign status_o.is_operand = itp_pkg::is_operand(char_rd_q);
  assign status_o.is_space   = (char_rd_q == itp_pkg::ChSpace);
  assign status_o.depth_zero = (depth_q == '0);
  assign status_o.prec_lt    = itp_pkg::precedence(cur_q) < itp_pkg::precedence(top_q);
  assign status_o.res_zero   = (res_cnt_q == '0);
  assign status_o.out_xfer   = out_xfer;
  assign status_o.out_end    = out_end_q;

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign end_mark_o   = out_end_q;
  assign nothing_o    = out_nothing_q;
  assign overflowed_o = out_ovf_q;

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q <= CapCnt) && (res_cnt_q <= CapCnt) && (count_q <= CapCnt))
    else $error("counter beyond capacity");

  a_no_accept_while_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !out_valid_q)
    else $error("input taken while a result is pending");

  a_empty_is_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_nothing_q) |-> out_end_q)
    else $error("empty result not marked as end");

  a_clean_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_end_q) |=> ##1 ((count_q == '0) && (depth_q == '0) &&
      (res_cnt_q == '0) && !dropped_q))
    else $error("state not cleared after final transfer");

  a_pop_needs_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (depth_q != '0))
    else $error("pop on empty stack");

endmodule

### hw/rtl/infix_to_prefix_converter_core.sv
// ----------------------------------------------------------------------------
// infix_to_prefix_converter_core
// Converts an ASCII infix expression into its prefix form.
// ----------------------------------------------------------------------------
// Input channel: one character per transfer on ch_i; last_i marks the final
// character of an expression. Characters beyond Capacity are dropped and
// reported through overflowed_o on every result of that expression.
// Output channel: one prefix character per transfer, end_mark_o on the last
// one. An expression with no output characters gives a single transfer with
// nothing_o and end_mark_o set and out_char_o zero.
// Sequence: while collecting, every offered input character is accepted.
// After the closing transfer the controller walks the buffer from its last
// stored character back to its first: operands go straight to the result
// memory, spaces are skipped, and each operator first pops every stack entry
// of higher precedence into the result memory and is then pushed. The stack
// is then flushed into the result memory, and the result characters leave
// from the last written to the first through the output register. Each
// operator is pushed and popped once. Memory reads are registered, and the
// stack takes one operation per cycle. A clean-up state follows the final
// transfer. Input is stalled from the closing transfer until that clean-up
// is done. When the receiver stalls, the output register holds its payload
// and the emission pauses. Reset clears all counters, the overflow flag and
// the state machine; memory contents are not cleared.
// ----------------------------------------------------------------------------
module infix_to_prefix_converter_core #(
  parameter int unsigned Capacity = itp_pkg::DefaultCapacity
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       end_mark_o,
  output logic       nothing_o,
  output logic       overflowed_o
);

  itp_pkg::itp_cmd_t    cmd;
  itp_pkg::itp_status_t status;

  assign in_stall_o = ~cmd.accept;

  itp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  itp_dp #(
    .Capacity (Capacity)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_valid_i   (in_valid_i),
    .ch_i         (ch_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .end_mark_o   (end_mark_o),
    .nothing_o    (nothing_o),
    .overflowed_o (overflowed_o)
  );

endmodule
